>>> design/eli_pkg.sv
// Shared types, codes and helper functions of the interrupt router.
`default_nettype none
package eli_pkg;

  localparam int NUM_LINES_DEF = 64;
  localparam int WORD_W        = 64;
  localparam int LINE_W        = 6;
  localparam int CNT_W         = 7;
  localparam int ROW_W         = 3;
  localparam int TBL_ROWS      = 8;
  localparam int LANES         = 8;
  localparam int CFG_IDX_W     = 2;

  localparam logic [1:0] OP_LINE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [3:0] SEL_ID       = 4'd0;
  localparam logic [3:0] SEL_MASK     = 4'd1;
  localparam logic [3:0] SEL_EDGE     = 4'd2;
  localparam logic [3:0] SEL_ENABLE   = 4'd3;
  localparam logic [3:0] SEL_CLEAR    = 4'd6;
  localparam logic [3:0] SEL_STATUS   = 4'd7;
  localparam logic [3:0] SEL_POLARITY = 4'd8;
  localparam logic [3:0] SEL_VECTOR   = 4'd9;
  localparam logic [3:0] SEL_ROUTE    = 4'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDENTITY   = 2'd1;

  localparam logic [CNT_W-1:0] LINE_COUNT_RST = 7'd64;
  localparam logic [7:0]       VEC_RST        = 8'h00;
  localparam logic [7:0]       RT_RST         = 8'h01;

  typedef enum logic [1:0] {TBL_NONE, TBL_VEC, TBL_RT} eli_tbl_src_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [LINE_W-1:0] line;
    logic              level;
    logic [3:0]        register_select;
    logic [2:0]        word_index;
    logic [2:0]        byte_offset;
    logic [1:0]        access_size;
    logic [WORD_W-1:0] write_data;
  } eli_item_t;

  // Work handed from the update stage to the output stage.
  typedef struct packed {
    logic [WORD_W-1:0] rd;
    eli_tbl_src_t      tbl_src;
    logic [2:0]        byte_offset;
    logic [1:0]        access_size;
    logic              c1_vld;
    logic              c1_lvl;
    logic [2:0]        c1_byte;
    logic              c2_vld;
    logic              c2_lvl;
    logic [2:0]        c2_byte;
  } eli_s1_t;

  typedef struct packed {
    logic              vec_we;
    logic              rt_we;
    logic [ROW_W-1:0]  wr_row;
    logic [LANES-1:0]  be;
    logic [WORD_W-1:0] wdata;
    logic              rd_en;
    logic [ROW_W-1:0]  a_row;
    logic [ROW_W-1:0]  b_row;
    logic [ROW_W-1:0]  rt_row;
  } eli_tbl_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] vec_a;
    logic [WORD_W-1:0] vec_b;
    logic [WORD_W-1:0] rt;
  } eli_rows_t;

  function automatic logic [WORD_W-1:0] size_mask(input logic [1:0] size);
    logic [WORD_W-1:0] m;
    case (size)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

  // Two-level priority encoder: lowest non-zero byte, then lowest bit in it.
  function automatic logic [LINE_W-1:0] lowest_bit(input logic [WORD_W-1:0] v);
    logic [LANES-1:0] nz;
    logic [2:0]       pos [LANES];
    logic [2:0]       grp;
    for (int g = 0; g < LANES; g++) begin
      nz[g]  = |v[8*g +: 8];
      pos[g] = 3'd0;
      for (int b = 7; b >= 0; b--) begin
        if (v[8*g + b]) pos[g] = 3'(b);
      end
    end
    grp = 3'd0;
    for (int g = LANES - 1; g >= 0; g--) begin
      if (nz[g]) grp = 3'(g);
    end
    return {grp, pos[grp]};
  endfunction

endpackage
`default_nettype wire

>>> design/eli_if.sv
// Channel interfaces: line events and bus accesses, results, configuration writes.
`default_nettype none
interface eli_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [5:0]  line;
  logic        level;
  logic [3:0]  register_select;
  logic [2:0]  word_index;
  logic [2:0]  byte_offset;
  logic [1:0]  access_size;
  logic [63:0] write_data;

  modport source (output valid, operation, line, level, register_select, word_index,
                  byte_offset, access_size, write_data, input ready);
  modport sink (input valid, operation, line, level, register_select, word_index,
                byte_offset, access_size, write_data, output ready);
endinterface

interface eli_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_data;
  logic        first_change_valid;
  logic [7:0]  first_change_target;
  logic        first_change_level;
  logic        second_change_valid;
  logic [7:0]  second_change_target;
  logic        second_change_level;

  modport source (output valid, read_data, first_change_valid, first_change_target,
                  first_change_level, second_change_valid, second_change_target,
                  second_change_level, input ready);
  modport sink (input valid, read_data, first_change_valid, first_change_target,
                first_change_level, second_change_valid, second_change_target,
                second_change_level, output ready);
endinterface

interface eli_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [63:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

>>> design/eli_tables.sv
// Vector and route byte tables with byte-lane writes and registered reads.
`default_nettype none
module eli_tables (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire eli_pkg::eli_tbl_req_t req,
  output eli_pkg::eli_rows_t       rows
);
  import eli_pkg::*;

  logic [WORD_W-1:0] vec_mem [TBL_ROWS];
  logic [WORD_W-1:0] rt_mem  [TBL_ROWS];
  logic [LANES-1:0]  vec_vld_r [TBL_ROWS];
  logic [LANES-1:0]  rt_vld_r  [TBL_ROWS];

  logic [WORD_W-1:0] a_data_r, b_data_r, rt_data_r;
  logic [LANES-1:0]  a_vld_r, b_vld_r, rt_vld_q_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      if (req.vec_we && req.be[k]) vec_mem[req.wr_row][8*k +: 8] <= req.wdata[8*k +: 8];
      if (req.rt_we && req.be[k])  rt_mem[req.wr_row][8*k +: 8]  <= req.wdata[8*k +: 8];
    end
  end

  // A byte never written reads as its reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_vld_r <= '{default: '0};
      rt_vld_r  <= '{default: '0};
    end else begin
      if (req.vec_we) vec_vld_r[req.wr_row] <= vec_vld_r[req.wr_row] | req.be;
      if (req.rt_we)  rt_vld_r[req.wr_row]  <= rt_vld_r[req.wr_row] | req.be;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      a_data_r   <= vec_mem[req.a_row];
      a_vld_r    <= vec_vld_r[req.a_row];
      b_data_r   <= vec_mem[req.b_row];
      b_vld_r    <= vec_vld_r[req.b_row];
      rt_data_r  <= rt_mem[req.rt_row];
      rt_vld_q_r <= rt_vld_r[req.rt_row];
    end
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      rows.vec_a[8*k +: 8] = a_vld_r[k]    ? a_data_r[8*k +: 8]  : VEC_RST;
      rows.vec_b[8*k +: 8] = b_vld_r[k]    ? b_data_r[8*k +: 8]  : VEC_RST;
      rows.rt[8*k +: 8]    = rt_vld_q_r[k] ? rt_data_r[8*k +: 8] : RT_RST;
    end
  end

endmodule
`default_nettype wire

>>> design/eli_core.sv
// Controller state, configuration registers and the combinational update logic.
`default_nettype none
module eli_core #(
  parameter int NUM_LINES = eli_pkg::NUM_LINES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          s0_vld,
  input  wire eli_pkg::eli_item_t            s0_item,
  output logic                               s1_rdy,
  input  wire logic                          s2_rdy,
  output logic                               s1_vld,
  output eli_pkg::eli_s1_t                   s1,
  output eli_pkg::eli_tbl_req_t              tbl_req,
  input  wire logic                          cfg_we,
  input  wire logic [eli_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [eli_pkg::WORD_W-1:0]    cfg_data
);
  import eli_pkg::*;

  logic [CNT_W-1:0]  line_count_r;
  logic [WORD_W-1:0] ident_r;
  logic [WORD_W-1:0] mask_r, edge_r, en_r, pol_r, pend_r, insv_r, prev_r;
  logic [WORD_W-1:0] mask_nxt, edge_nxt, en_nxt, pol_nxt, pend_nxt, insv_nxt, prev_nxt;
  logic              s1_vld_r;
  eli_s1_t           s1_r, s1_nxt;

  logic              s0_fire;
  logic [WORD_W-1:0] width, lanes, data, b, v1, v2, insv_mid, rd_src;
  logic [5:0]        shamt;
  logic [LINE_W-1:0] n1, n2;
  logic              lvl1, in_range;
  eli_tbl_src_t      tbl_src;

  assign s1_rdy  = !s1_vld_r || s2_rdy;
  assign s0_fire = s0_vld && s1_rdy;
  assign s1_vld  = s1_vld_r;
  assign s1      = s1_r;

  assign width    = size_mask(s0_item.access_size);
  assign shamt    = {s0_item.byte_offset, 3'b000};
  assign lanes    = width << shamt;
  assign data     = (s0_item.write_data & width) << shamt;
  assign b        = {{(WORD_W-1){1'b0}}, 1'b1} << s0_item.line;
  assign in_range = ({1'b0, s0_item.line} < line_count_r) &&
                    ({1'b0, s0_item.line} < CNT_W'(NUM_LINES));

  always_comb begin
    mask_nxt = mask_r;
    edge_nxt = edge_r;
    en_nxt   = en_r;
    pol_nxt  = pol_r;
    pend_nxt = pend_r;
    insv_nxt = insv_r;
    prev_nxt = prev_r;
    insv_mid = insv_r;
    v1       = '0;
    v2       = '0;
    n1       = '0;
    n2       = '0;
    lvl1     = 1'b0;
    rd_src   = '0;
    tbl_src  = TBL_NONE;
    case (s0_item.operation)
      OP_LINE: begin
        if (in_range) begin
          if (s0_item.level) begin
            // Edge-mode lines latch only on a low-to-high transition.
            if (!edge_r[s0_item.line] || !prev_r[s0_item.line]) pend_nxt = pend_r | b;
            prev_nxt = prev_r | b;
          end else begin
            if (!edge_r[s0_item.line]) pend_nxt = pend_r & ~b;
            prev_nxt = prev_r & ~b;
          end
          lvl1 = s0_item.level;
          v1   = s0_item.level ? (b & pend_nxt & ~mask_r) : (b & insv_r & ~pend_nxt);
          n1   = lowest_bit(v1);
          if (|v1) begin
            if (s0_item.level) insv_nxt = insv_r | (64'd1 << n1);
            else               insv_nxt = insv_r & ~(64'd1 << n1);
          end
        end
      end
      OP_READ: begin
        unique case (s0_item.register_select)
          SEL_ID:       rd_src = ident_r;
          SEL_MASK:     rd_src = mask_r;
          SEL_EDGE:     rd_src = edge_r;
          SEL_ENABLE:   rd_src = en_r;
          SEL_STATUS:   rd_src = insv_r & ~mask_r;
          SEL_POLARITY: rd_src = pol_r;
          SEL_VECTOR:   tbl_src = TBL_VEC;
          SEL_ROUTE:    tbl_src = TBL_RT;
          default:      rd_src = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (s0_item.register_select)
          SEL_MASK: begin
            // Newly unmasked lines may raise, newly masked ones may lower.
            mask_nxt = (mask_r & ~lanes) | data;
            lvl1     = 1'b1;
            v1       = mask_r & ~data & pend_r & ~mask_nxt;
            n1       = lowest_bit(v1);
            insv_mid = (|v1) ? (insv_r | (64'd1 << n1)) : insv_r;
            v2       = ~mask_r & data & insv_mid & ~pend_r;
            n2       = lowest_bit(v2);
            insv_nxt = (|v2) ? (insv_mid & ~(64'd1 << n2)) : insv_mid;
          end
          SEL_EDGE:     edge_nxt = (edge_r & ~lanes) | data;
          SEL_ENABLE:   en_nxt   = (en_r & ~lanes) | data;
          SEL_POLARITY: pol_nxt  = (pol_r & ~lanes) | data;
          SEL_CLEAR: begin
            if (|(edge_r & data)) begin
              pend_nxt = pend_r & ~data;
              v1       = data & insv_r & ~pend_nxt;
              n1       = lowest_bit(v1);
              insv_nxt = insv_r & ~data;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    s1_nxt.rd          = (rd_src >> shamt) & width;
    s1_nxt.tbl_src     = tbl_src;
    s1_nxt.byte_offset = s0_item.byte_offset;
    s1_nxt.access_size = s0_item.access_size;
    s1_nxt.c1_vld      = |v1;
    s1_nxt.c1_lvl      = (|v1) && lvl1;
    s1_nxt.c1_byte     = n1[2:0];
    s1_nxt.c2_vld      = |v2;
    s1_nxt.c2_lvl      = 1'b0;
    s1_nxt.c2_byte     = n2[2:0];
  end

  always_comb begin
    tbl_req.vec_we = s0_fire && (s0_item.operation == OP_WRITE) &&
                     (s0_item.register_select == SEL_VECTOR);
    tbl_req.rt_we  = s0_fire && (s0_item.operation == OP_WRITE) &&
                     (s0_item.register_select == SEL_ROUTE);
    tbl_req.wr_row = s0_item.word_index;
    for (int k = 0; k < LANES; k++) tbl_req.be[k] = lanes[8*k];
    tbl_req.wdata  = data;
    tbl_req.rd_en  = s0_fire;
    tbl_req.a_row  = (tbl_src == TBL_VEC) ? s0_item.word_index : n1[LINE_W-1:3];
    tbl_req.b_row  = n2[LINE_W-1:3];
    tbl_req.rt_row = s0_item.word_index;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= LINE_COUNT_RST;
      ident_r      <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_LINE_COUNT) line_count_r <= cfg_data[CNT_W-1:0];
      if (cfg_idx == CFG_IDENTITY)   ident_r      <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '1;
      edge_r   <= '0;
      en_r     <= '0;
      pol_r    <= '0;
      pend_r   <= '0;
      insv_r   <= '0;
      prev_r   <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      if (s0_fire) begin
        mask_r <= mask_nxt;
        edge_r <= edge_nxt;
        en_r   <= en_nxt;
        pol_r  <= pol_nxt;
        pend_r <= pend_nxt;
        insv_r <= insv_nxt;
        prev_r <= prev_nxt;
      end
      if (s0_fire)     s1_vld_r <= 1'b1;
      else if (s2_rdy) s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire) s1_r <= s1_nxt;
  end

  a_second_only_on_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_fire && (|v2)) |->
      (s0_item.operation == OP_WRITE && s0_item.register_select == SEL_MASK))
    else $error("second parent change outside a mask write");

  a_raise_sets_service: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_fire && (|v1) && lvl1) |=> insv_r[$past(n1)])
    else $error("raised line not marked in service");

  a_no_spurious_service: assert property (@(posedge clk) disable iff (!rst_n)
    !(s0_fire && (|v1) && lvl1) |=> ((insv_r & ~$past(insv_r)) == '0))
    else $error("in-service bit set without a raise");

  a_ignored_line: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_fire && s0_item.operation == OP_LINE && !in_range) |=>
      ($stable(pend_r) && $stable(insv_r) && $stable(prev_r)))
    else $error("out-of-range line event changed state");

endmodule
`default_nettype wire

>>> design/eli_out.sv
// Output stage: table byte selection, read alignment and the result register.
`default_nettype none
module eli_out (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              s1_vld,
  input  wire eli_pkg::eli_s1_t  s1,
  input  wire eli_pkg::eli_rows_t rows,
  output logic                   s2_rdy,
  eli_out_if.source              out_ch
);
  import eli_pkg::*;

  logic              out_vld_r;
  logic [WORD_W-1:0] rd_r, rd_nxt, tbl_row;
  logic              c1_vld_r, c1_lvl_r, c2_vld_r, c2_lvl_r;
  logic [7:0]        c1_tgt_r, c1_tgt_nxt, c2_tgt_r, c2_tgt_nxt;
  logic              s1_fire;

  assign s2_rdy  = !out_vld_r || out_ch.ready;
  assign s1_fire = s1_vld && s2_rdy;

  always_comb begin
    tbl_row    = (s1.tbl_src == TBL_VEC) ? rows.vec_a : rows.rt;
    rd_nxt     = (s1.tbl_src == TBL_NONE) ? s1.rd :
                 ((tbl_row >> {s1.byte_offset, 3'b000}) & size_mask(s1.access_size));
    c1_tgt_nxt = s1.c1_vld ? rows.vec_a[{s1.c1_byte, 3'b000} +: 8] : 8'h00;
    c2_tgt_nxt = s1.c2_vld ? rows.vec_b[{s1.c2_byte, 3'b000} +: 8] : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      rd_r     <= rd_nxt;
      c1_vld_r <= s1.c1_vld;
      c1_tgt_r <= c1_tgt_nxt;
      c1_lvl_r <= s1.c1_lvl;
      c2_vld_r <= s1.c2_vld;
      c2_tgt_r <= c2_tgt_nxt;
      c2_lvl_r <= s1.c2_lvl;
    end
  end

  assign out_ch.valid                = out_vld_r;
  assign out_ch.read_data            = rd_r;
  assign out_ch.first_change_valid   = c1_vld_r;
  assign out_ch.first_change_target  = c1_tgt_r;
  assign out_ch.first_change_level   = c1_lvl_r;
  assign out_ch.second_change_valid  = c2_vld_r;
  assign out_ch.second_change_target = c2_tgt_r;
  assign out_ch.second_change_level  = c2_lvl_r;

endmodule
`default_nettype wire

>>> design/edge_level_interrupt_router_unit.sv
// Top level of the 64-line edge/level interrupt router.
//
//   Channel  Dir  Carries
//   in_ch    in   line event or register access (operation, line, level, ...)
//   out_ch   out  read data and up to two parent line changes
//   cfg_ch   in   line_count (index 0) and identity word (index 1) writes
//
// One transaction is accepted per cycle while in_ch.ready is high; each gives
// exactly one result, after passing the input register, the state update with
// table read and the output register in turn. The state update for a transaction
// happens in the cycle in which it leaves the input register. Reset is
// synchronous and active low; the tables clear at once. A stalled output holds
// each stage in turn, and in_ch.ready drops only when all three stages are full.
// cfg_ch.ready is always high.
`default_nettype none
module edge_level_interrupt_router_unit #(
  parameter int NUM_LINES = eli_pkg::NUM_LINES_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  eli_in_if.sink    in_ch,
  eli_out_if.source out_ch,
  eli_cfg_if.sink   cfg_ch
);
  import eli_pkg::*;

  logic         s0_vld_r;
  eli_item_t    s0_item_r, in_item;
  logic         s1_rdy, s2_rdy, s1_vld, in_fire;
  eli_s1_t      s1;
  eli_tbl_req_t tbl_req;
  eli_rows_t    rows;

  assign in_ch.ready  = !s0_vld_r || s1_rdy;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    in_item.operation       = in_ch.operation;
    in_item.line            = in_ch.line;
    in_item.level           = in_ch.level;
    in_item.register_select = in_ch.register_select;
    in_item.word_index      = in_ch.word_index;
    in_item.byte_offset     = in_ch.byte_offset;
    in_item.access_size     = in_ch.access_size;
    in_item.write_data      = in_ch.write_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (in_fire) begin
      s0_vld_r <= 1'b1;
    end else if (s1_rdy) begin
      s0_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s0_item_r <= in_item;
  end

  eli_core #(.NUM_LINES(NUM_LINES)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .s0_vld   (s0_vld_r),
    .s0_item  (s0_item_r),
    .s1_rdy   (s1_rdy),
    .s2_rdy   (s2_rdy),
    .s1_vld   (s1_vld),
    .s1       (s1),
    .tbl_req  (tbl_req),
    .cfg_we   (cfg_ch.valid && cfg_ch.ready),
    .cfg_idx  (cfg_ch.reg_index),
    .cfg_data (cfg_ch.wr_data)
  );

  eli_tables u_tables (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rows  (rows)
  );

  eli_out u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .s1_vld (s1_vld),
    .s1     (s1),
    .rows   (rows),
    .s2_rdy (s2_rdy),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
